// ===== hdl/leader_mode_cluster_assign_top_defines.svh =====
// ----------------------------------------------------------------------------
// leader_mode_cluster_assign_top_defines
// Assertion macros shared by the clustering block.
// ----------------------------------------------------------------------------
`ifndef LEADER_MODE_CLUSTER_ASSIGN_TOP_DEFINES_SVH
`define LEADER_MODE_CLUSTER_ASSIGN_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(lbl, ck, rstn, expr) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (expr)) \
		else $error("assertion failed");
`define ASSERT_IMPLIES(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, ck, rstn, expr)
`define ASSERT_IMPLIES(lbl, ck, rstn, ante, cons)
`endif

`endif

// ===== hdl/lmca_pkg.sv =====
// ----------------------------------------------------------------------------
// lmca_pkg
// Types and constants of the leader mode clustering block.
// ----------------------------------------------------------------------------
package lmca_pkg;

	localparam int COORD_W           = 24;
	localparam int DIFF_W            = 25;
	localparam int SQ_W              = 50;
	localparam int RADIUS_W          = 52;
	localparam int CIDX_W            = 6;
	localparam int MAX_MODES_DEFAULT = 64;
	localparam logic [RADIUS_W-1:0] RADIUS_RESET = 52'd16384;

	typedef struct packed {
		logic                       first_of_set;
		logic signed [COORD_W-1:0]  x_coord;
		logic signed [COORD_W-1:0]  y_coord;
		logic signed [COORD_W-1:0]  z_coord;
	} in_word_t;

	typedef struct packed {
		logic [CIDX_W-1:0] cluster_index;
		logic              is_new;
		logic              table_full;
	} out_word_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
	} mode_t;

endpackage

// ===== hdl/lmca_dist.sv =====
// ----------------------------------------------------------------------------
// lmca_dist
// Three-stage squared-distance pipeline: magnitude, square, sum and compare.
// ----------------------------------------------------------------------------
module lmca_dist #(
	parameter int AW = 6
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                kill,
	input  logic                                in_valid,
	input  logic [AW-1:0]                       in_idx,
	input  lmca_pkg::mode_t                     point,
	input  lmca_pkg::mode_t                     entry,
	input  logic [lmca_pkg::RADIUS_W-1:0]       radius,
	output logic                                out_valid,
	output logic                                out_hit,
	output logic [AW-1:0]                       out_idx,
	output logic                                pending
);

	localparam int DW = lmca_pkg::DIFF_W;
	localparam int QW = lmca_pkg::SQ_W;
	localparam int RW = lmca_pkg::RADIUS_W;

	logic signed [DW-1:0] dx_c, dy_c, dz_c;
	logic [DW-1:0]        mx_c, my_c, mz_c;
	logic [RW-1:0]        sum_c;

	logic                 v_s2, v_s3, v_s4;
	logic [AW-1:0]        idx_s2, idx_s3, idx_s4;
	logic [DW-1:0]        mx_s2, my_s2, mz_s2;
	logic [QW-1:0]        sqx_s3, sqy_s3, sqz_s3;
	logic                 hit_s4;

	always_comb begin
		dx_c = DW'(point.x) - DW'(entry.x);
		dy_c = DW'(point.y) - DW'(entry.y);
		dz_c = DW'(point.z) - DW'(entry.z);
		mx_c = dx_c[DW-1] ? DW'(-dx_c) : DW'(dx_c);
		my_c = dy_c[DW-1] ? DW'(-dy_c) : DW'(dy_c);
		mz_c = dz_c[DW-1] ? DW'(-dz_c) : DW'(dz_c);
		sum_c = RW'(sqx_s3) + RW'(sqy_s3) + RW'(sqz_s3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (kill) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s2 <= in_valid;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		idx_s2 <= in_idx;
		mx_s2  <= mx_c;
		my_s2  <= my_c;
		mz_s2  <= mz_c;
		idx_s3 <= idx_s2;
		sqx_s3 <= mx_s2 * mx_s2;
		sqy_s3 <= my_s2 * my_s2;
		sqz_s3 <= mz_s2 * mz_s2;
		idx_s4 <= idx_s3;
		hit_s4 <= (sum_c <= radius);
	end

	assign out_valid = v_s4;
	assign out_hit   = hit_s4;
	assign out_idx   = idx_s4;
	assign pending   = v_s2 | v_s3 | v_s4;

endmodule

// ===== hdl/leader_mode_cluster_assign_top.sv =====
// ----------------------------------------------------------------------------
// leader_mode_cluster_assign_top
// Leader clustering of 3D points: match the first stored mode within the
// squared radius, else append the point as a new mode or flag a full table.
// ----------------------------------------------------------------------------
// channel   | handshake          | word
// ----------+--------------------+------------------------------------
// input     | start / busy       | item   (first_of_set, x, y, z)
// result    | done (strobe)      | result (cluster_index, is_new, full)
// config    | cfg_we             | cfg_wdata (radius_squared)
//
// done rises when a stored mode hits or, once every stored mode has missed,
// when the point is appended or the table reports full. Modes are
// read from the mode memory one per cycle and run through a three-stage
// distance pipeline. busy stays high from acceptance until done, so one item
// is processed at a time. Reset empties the table; the memory
// needs no clearing pass. done lasts one cycle and cannot be stalled.
// ----------------------------------------------------------------------------
`include "leader_mode_cluster_assign_top_defines.svh"

module leader_mode_cluster_assign_top #(
	parameter int MAX_MODES = lmca_pkg::MAX_MODES_DEFAULT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  lmca_pkg::in_word_t             item,
	output logic                           done,
	output lmca_pkg::out_word_t            result,
	input  logic                           cfg_we,
	input  logic [lmca_pkg::RADIUS_W-1:0]  cfg_wdata
);

	localparam int AW = (MAX_MODES > 1) ? $clog2(MAX_MODES) : 1;
	localparam int CW = $clog2(MAX_MODES + 1);
	localparam int IW = lmca_pkg::CIDX_W;
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_MODES);

	typedef enum logic [0:0] {ST_IDLE, ST_SCAN} state_t;

	state_t                         state_q;
	logic [CW-1:0]                  count_q;
	logic [CW-1:0]                  issue_q;
	lmca_pkg::in_word_t             point_q;
	logic [lmca_pkg::RADIUS_W-1:0]  radius_q;
	logic                           rd_valid_s1;
	logic [AW-1:0]                  rd_idx_s1;
	lmca_pkg::mode_t                rd_data_s1;
	logic                           done_q;
	lmca_pkg::out_word_t            result_q;

	lmca_pkg::mode_t                mode_mem_q [MAX_MODES];

	lmca_pkg::mode_t                point_c;
	logic                           dist_valid, dist_hit, dist_pending;
	logic [AW-1:0]                  dist_idx;
	logic                           hit_found, scan_empty, issue_en, wr_en, kill;

	always_comb begin
		point_c.x  = point_q.x_coord;
		point_c.y  = point_q.y_coord;
		point_c.z  = point_q.z_coord;
		hit_found  = (state_q == ST_SCAN) && dist_valid && dist_hit;
		scan_empty = (state_q == ST_SCAN) && (issue_q == count_q) && !rd_valid_s1
			&& !dist_pending;
		issue_en   = (state_q == ST_SCAN) && (issue_q < count_q) && !hit_found;
		wr_en      = scan_empty && !hit_found && (count_q != MAX_CNT);
		kill       = hit_found || scan_empty;
	end

	lmca_dist #(
		.AW (AW)
	) u_dist (
		.clk       (clk),
		.arst_n    (arst_n),
		.kill      (kill),
		.in_valid  (rd_valid_s1),
		.in_idx    (rd_idx_s1),
		.point     (point_c),
		.entry     (rd_data_s1),
		.radius    (radius_q),
		.out_valid (dist_valid),
		.out_hit   (dist_hit),
		.out_idx   (dist_idx),
		.pending   (dist_pending)
	);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mode_mem_q[count_q[AW-1:0]] <= point_c;
		end
		if (issue_en) begin
			rd_data_s1 <= mode_mem_q[issue_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			issue_q     <= '0;
			point_q     <= '0;
			radius_q    <= lmca_pkg::RADIUS_RESET;
			rd_valid_s1 <= 1'b0;
			rd_idx_s1   <= '0;
			done_q      <= 1'b0;
			result_q    <= '0;
		end else begin
			done_q      <= 1'b0;
			rd_valid_s1 <= issue_en;
			rd_idx_s1   <= issue_q[AW-1:0];
			if (cfg_we) begin
				radius_q <= cfg_wdata;
			end
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						point_q <= item;
						issue_q <= '0;
						if (item.first_of_set) begin
							count_q <= '0;
						end
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (issue_en) begin
						issue_q <= issue_q + 1'b1;
					end
					if (hit_found) begin
						done_q                 <= 1'b1;
						result_q.cluster_index <= IW'(dist_idx);
						result_q.is_new        <= 1'b0;
						result_q.table_full    <= 1'b0;
						state_q                <= ST_IDLE;
					end else if (scan_empty) begin
						done_q <= 1'b1;
						if (count_q != MAX_CNT) begin
							result_q.cluster_index <= IW'(count_q);
							result_q.is_new        <= 1'b1;
							result_q.table_full    <= 1'b0;
							count_q                <= count_q + 1'b1;
						end else begin
							result_q.cluster_index <= '0;
							result_q.is_new        <= 1'b0;
							result_q.table_full    <= 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

	`ASSERT_ALWAYS(a_count_bound, clk, arst_n, count_q <= MAX_CNT)
	`ASSERT_IMPLIES(a_done_idle, clk, arst_n, done, !busy)
	`ASSERT_IMPLIES(a_new_grows, clk, arst_n, done && result.is_new, count_q == $past(count_q) + 1'b1)
	`ASSERT_IMPLIES(a_full_count, clk, arst_n, done && result.table_full, count_q == MAX_CNT)

endmodule

// ===== sim/leader_mode_cluster_assign_checker.sv =====
// ----------------------------------------------------------------------------
// leader_mode_cluster_assign_checker
// Watches the item, result and radius channels of the clustering block,
// keeps its own mode table to predict each cluster assignment, and checks
// every result word against the oldest pending assignment in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module leader_mode_cluster_assign_checker #(
	parameter int MAX_MODES = lmca_pkg::MAX_MODES_DEFAULT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic                           busy,
	input  lmca_pkg::in_word_t             item,
	input  logic                           done,
	input  lmca_pkg::out_word_t            result,
	input  logic                           cfg_we,
	input  logic [lmca_pkg::RADIUS_W-1:0]  cfg_wdata,
	output int                             errors,
	output int                             pending
);

	localparam int IW = lmca_pkg::CIDX_W;

	logic [lmca_pkg::RADIUS_W-1:0] radius_sq;
	lmca_pkg::mode_t               modes [MAX_MODES];
	int                            mode_count;
	lmca_pkg::out_word_t           assignments_due [$];

	function automatic lmca_pkg::out_word_t assign_point(input lmca_pkg::in_word_t p);
		lmca_pkg::out_word_t r;
		longint              dx;
		longint              dy;
		longint              dz;
		logic [63:0]         sq_dist;
		bit                  hit;
		r = '0;
		hit = 1'b0;
		if (p.first_of_set)
			mode_count = 0;
		for (int c = 0; c < mode_count && !hit; c++) begin
			dx = longint'(p.x_coord) - longint'(modes[c].x);
			dy = longint'(p.y_coord) - longint'(modes[c].y);
			dz = longint'(p.z_coord) - longint'(modes[c].z);
			sq_dist = 64'(dx * dx + dy * dy + dz * dz);
			if (sq_dist <= {12'd0, radius_sq}) begin
				hit = 1'b1;
				r.cluster_index = IW'(c);
			end
		end
		if (!hit) begin
			if (mode_count < MAX_MODES) begin
				modes[mode_count].x = p.x_coord;
				modes[mode_count].y = p.y_coord;
				modes[mode_count].z = p.z_coord;
				r.cluster_index = IW'(mode_count);
				r.is_new = 1'b1;
				mode_count++;
			end else begin
				r.table_full = 1'b1;
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		lmca_pkg::out_word_t want;
		lmca_pkg::out_word_t next_due;
		if (!arst_n) begin
			radius_sq = lmca_pkg::RADIUS_RESET;
			mode_count = 0;
			assignments_due.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (done) begin
				if (assignments_due.size() == 0) begin
					errors++;
					$display("%0t: unexpected result word, expected none actual %h",
						$time, result);
				end else begin
					want = assignments_due.pop_front();
					if (result.cluster_index !== want.cluster_index) begin
						errors++;
						$display("%0t: cluster_index expected %0d actual %0d",
							$time, want.cluster_index, result.cluster_index);
					end
					if (result.is_new !== want.is_new) begin
						errors++;
						$display("%0t: is_new expected %0b actual %0b",
							$time, want.is_new, result.is_new);
					end
					if (result.table_full !== want.table_full) begin
						errors++;
						$display("%0t: table_full expected %0b actual %0b",
							$time, want.table_full, result.table_full);
					end
				end
			end
			if (cfg_we)
				radius_sq = cfg_wdata;
			if (start && !busy) begin
				next_due = assign_point(item);
				assignments_due = {assignments_due, next_due};
			end
			pending = assignments_due.size();
		end
	end

endmodule

// ===== sim/leader_mode_cluster_assign_top_tb.sv =====
// ----------------------------------------------------------------------------
// leader_mode_cluster_assign_top_tb
// Drives directed and clustered random points through the clustering block
// across several radius settings, from zero to the full register range,
// including a filled mode table and table flushes; a separate checker
// predicts and compares every result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module leader_mode_cluster_assign_top_tb;

	localparam int MAX_MODES  = lmca_pkg::MAX_MODES_DEFAULT;
	localparam int CYCLE_CAP  = 1000000;
	localparam int CW         = lmca_pkg::COORD_W;
	localparam int RW         = lmca_pkg::RADIUS_W;
	localparam logic [RW-1:0] RADIUS_MAX = {RW{1'b1}};

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                busy;
	lmca_pkg::in_word_t  item = '0;
	logic                done;
	lmca_pkg::out_word_t result;
	logic                cfg_we = 1'b0;
	logic [RW-1:0]       cfg_wdata = '0;
	int                  errors;
	int                  pending;
	int                  cycles = 0;
	bit                  burst = 1'b0;

	leader_mode_cluster_assign_top #(.MAX_MODES(MAX_MODES)) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	leader_mode_cluster_assign_checker #(.MAX_MODES(MAX_MODES)) u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.errors    (errors),
		.pending   (pending)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_CAP) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (burst || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 60);
	endfunction

	task automatic send_point(input logic first, input logic [CW-1:0] x,
			input logic [CW-1:0] y, input logic [CW-1:0] z);
		lmca_pkg::in_word_t w;
		int                 gap;
		w.first_of_set = first;
		w.x_coord = x;
		w.y_coord = y;
		w.z_coord = z;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		item <= w;
		do @(posedge clk); while (busy);
	endtask

	task automatic drain();
		start <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_radius(input logic [RW-1:0] value);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// points cluster around a few random centers, jittered on the scale of
	// the radius; a share (all of them with scatter set) is full-range noise
	task automatic run_phase(input logic [RW-1:0] radius, input int count,
			input bit scatter);
		logic [CW-1:0] cx [8];
		logic [CW-1:0] cy [8];
		logic [CW-1:0] cz [8];
		int            centers;
		int            spread;
		int            k;
		real           s;
		logic          first;
		set_radius(radius);
		burst = ($urandom_range(0, 3) == 0);
		centers = $urandom_range(1, 8);
		for (int i = 0; i < 8; i++) begin
			cx[i] = CW'($urandom);
			cy[i] = CW'($urandom);
			cz[i] = CW'($urandom);
		end
		s = $sqrt(real'(radius));
		if (s > 4194304.0)
			s = 4194304.0;
		spread = int'(s) + 2;
		for (int i = 0; i < count; i++) begin
			first = !scatter && ($urandom_range(0, 59) == 0);
			if (scatter || $urandom_range(0, 9) == 0) begin
				send_point(first, CW'($urandom), CW'($urandom),
					CW'($urandom));
			end else begin
				k = $urandom_range(0, centers - 1);
				send_point(first,
					cx[k] + CW'(int'($urandom_range(0, 2 * spread)) - spread),
					cy[k] + CW'(int'($urandom_range(0, 2 * spread)) - spread),
					cz[k] + CW'(int'($urandom_range(0, 2 * spread)) - spread));
			end
			if ($urandom_range(0, 49) == 0)
				burst = !burst;
		end
		burst = 1'b0;
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: boundary of the reset radius, first-match order, extremes
		send_point(1'b1, 24'sd0, 24'sd0, 24'sd0);
		send_point(1'b0, 24'sd128, 24'sd0, 24'sd0);
		send_point(1'b0, 24'sd0, -24'sd128, 24'sd0);
		send_point(1'b0, 24'sd129, 24'sd0, 24'sd0);
		send_point(1'b0, 24'sd0, 24'sd0, 24'sd129);
		send_point(1'b0, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
		send_point(1'b0, 24'h800000, 24'h800000, 24'h800000);
		send_point(1'b0, 24'h7FFFFF, 24'h800000, 24'h7FFFFF);
		send_point(1'b0, 24'h800000, 24'h7FFFFF, 24'h800000);
		send_point(1'b0, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
		send_point(1'b0, 24'h7FFF7F, 24'h7FFFFF, 24'h7FFFFF);
		send_point(1'b0, -24'sd1, -24'sd1, -24'sd1);
		send_point(1'b0, 24'sd64, 24'sd0, 24'sd0);
		send_point(1'b1, 24'sd64, 24'sd0, 24'sd0);
		send_point(1'b0, 24'h800000, 24'h800000, 24'h800000);
		send_point(1'b0, 24'h555555, 24'hAAAAAA, 24'h555555);
		send_point(1'b0, 24'hAAAAAA, 24'h555555, 24'hAAAAAA);

		// fill the table with an exact-match radius, then overflow it
		run_phase('0, 140, 1'b1);
		run_phase(RADIUS_MAX, 60, 1'b1);
		run_phase(RADIUS_MAX, 40, 1'b0);
		run_phase(RW'(1), 80, 1'b0);
		run_phase(lmca_pkg::RADIUS_RESET, 100, 1'b0);
		run_phase(RW'($urandom_range(0, 1 << 20)), 100, 1'b0);
		run_phase(RW'({$urandom, $urandom} >> 24), 100, 1'b0);
		run_phase(RW'({$urandom, $urandom}), 60, 1'b0);
		run_phase('0, 100, 1'b0);
		run_phase(RW'($urandom_range(0, 1 << 24)), 120, 1'b0);

		drain();
		repeat (10) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/lmca_pkg.sv
hdl/lmca_dist.sv
hdl/leader_mode_cluster_assign_top.sv
sim/leader_mode_cluster_assign_checker.sv
sim/leader_mode_cluster_assign_top_tb.sv
